// ===== sv/rgba_pixel_blender_macros.svh =====
// ----------------------------------------------------------------------------
// RGBA pixel blender assertion macros
// Shared assertion forms for the blender; each expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef RGBA_PIXEL_BLENDER_MACROS_SVH
`define RGBA_PIXEL_BLENDER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RPB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define RPB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/rpb_pkg.sv =====
// ----------------------------------------------------------------------------
// RGBA pixel blender package
// Types, mode codes and constants shared by the blender modules.
// ----------------------------------------------------------------------------
package rpb_pkg;

  // Blend mode codes.
  typedef enum logic [2:0] {
    MODE_DIRECT_XOR  = 3'd0,
    MODE_XOR         = 3'd1,
    MODE_ADDITIVE    = 3'd2,
    MODE_OVERLAY     = 3'd3,
    MODE_INVERT_DROP = 3'd4,
    MODE_DROP        = 3'd5,
    MODE_REPLACE     = 3'd6,
    MODE_XOR_ALL     = 3'd7
  } mode_t;

  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned PROD_W   = CHAN_W + WEIGHT_W;
  localparam int unsigned NUM_LANES = 6;

  // Full opacity weight is 255 * 255.
  localparam logic [WEIGHT_W-1:0] FULL_WEIGHT       = 16'd65025;
  localparam logic [WEIGHT_W-1:0] OVERLAY_THRESHOLD = 16'd16129;
  localparam logic [CHAN_W-1:0]   CHAN_MAX          = 8'd255;

  // One RGBA pixel.
  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
    logic [CHAN_W-1:0] a;
  } pix_t;

  // Control that travels alongside the pixel data.
  typedef struct packed {
    mode_t mode;
    logic  over;
  } ctrl_t;

endpackage

// ===== sv/rpb_scale_lane.sv =====
// ----------------------------------------------------------------------------
// RGBA pixel blender scaling lane
// Computes floor(chan * weight / 65025) in three registered stages.
// ----------------------------------------------------------------------------
module rpb_scale_lane (
  input  logic                           clk,
  input  logic [rpb_pkg::CHAN_W-1:0]     chan,
  input  logic [rpb_pkg::WEIGHT_W-1:0]   weight,
  output logic [rpb_pkg::CHAN_W-1:0]     scaled
);
  import rpb_pkg::*;

  // Divide a value below 2^24 by 255: estimate with x*257 >> 16, which is
  // at most one low, then correct with one compare and add.
  function automatic logic [WEIGHT_W-1:0] div255(input logic [PROD_W-1:0] x);
    logic [PROD_W+8:0] est;
    logic [16:0]       q0;
    logic [PROD_W:0]   rem;
    begin
      est = {1'b0, x, 8'd0} + {9'd0, x};
      q0  = est[32:16];
      rem = {1'b0, x} - ({q0, 8'd0} - {8'd0, q0});
      if (rem >= 25'd255) begin
        q0 = q0 + 17'd1;
      end
      div255 = q0[WEIGHT_W-1:0];
    end
  endfunction

  logic [PROD_W-1:0]   prod;
  logic [WEIGHT_W-1:0] quot1;

  // Product stage, then two divide-by-255 steps.
  always_ff @(posedge clk) begin
    prod   <= PROD_W'(chan) * PROD_W'(weight);
    quot1  <= div255(prod);
    scaled <= CHAN_W'(div255({8'd0, quot1}));
  end

endmodule

// ===== sv/rpb_merge.sv =====
// ----------------------------------------------------------------------------
// RGBA pixel blender merge stage
// Combines raw and scaled channels according to the mode into the result.
// ----------------------------------------------------------------------------
module rpb_merge (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       valid,
  input  rpb_pkg::ctrl_t             ctrl,
  input  rpb_pkg::pix_t              base_pix,
  input  rpb_pkg::pix_t              top_pix,
  input  rpb_pkg::pix_t              base_scl,
  input  rpb_pkg::pix_t              top_scl,
  output logic                       done,
  output rpb_pkg::pix_t              result
);
  import rpb_pkg::*;

  function automatic logic [CHAN_W-1:0] sat_add(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b);
    logic [CHAN_W:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      sat_add = s[CHAN_W] ? CHAN_MAX : s[CHAN_W-1:0];
    end
  endfunction

  pix_t result_next;

  // Select the blended pixel for the mode.
  always_comb begin
    result_next = base_pix;
    unique case (ctrl.mode)
      MODE_DIRECT_XOR: begin
        result_next.r = base_pix.r ^ top_pix.r;
        result_next.g = base_pix.g ^ top_pix.g;
        result_next.b = base_pix.b ^ top_pix.b;
      end
      MODE_XOR: begin
        result_next.r = base_scl.r ^ top_scl.r;
        result_next.g = base_scl.g ^ top_scl.g;
        result_next.b = base_scl.b ^ top_scl.b;
      end
      MODE_ADDITIVE: begin
        result_next.r = sat_add(base_scl.r, top_scl.r);
        result_next.g = sat_add(base_scl.g, top_scl.g);
        result_next.b = sat_add(base_scl.b, top_scl.b);
      end
      MODE_OVERLAY: begin
        if (ctrl.over) begin
          result_next.r = top_pix.r;
          result_next.g = top_pix.g;
          result_next.b = top_pix.b;
        end
      end
      MODE_INVERT_DROP: begin
        result_next.a = CHAN_MAX - top_pix.a;
      end
      MODE_DROP: begin
        result_next.a = top_pix.a;
      end
      MODE_REPLACE: begin
        result_next = top_pix;
      end
      MODE_XOR_ALL: begin
        result_next = base_pix ^ top_pix;
      end
      default: begin
        result_next = base_pix;
      end
    endcase
  end

  // Output register and its strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid;
    end
    result <= result_next;
  end

endmodule

// ===== sv/rgba_pixel_blender.sv =====
// ----------------------------------------------------------------------------
// RGBA pixel blender
// Blends a top RGBA pixel over a base pixel under one of eight modes.
// ----------------------------------------------------------------------------
//  Channel   Ports                                         Handshake
//  --------  --------------------------------------------  ----------------
//  command   mode, base_*, top_*, opacity                  start / busy
//  result    out_red, out_green, out_blue, out_alpha       done (strobe)
//
//  One transaction is taken every cycle while busy is low. Its result strobe
//  is registered through the weight multiply, the lane multiply, two
//  divide-by-255 steps and the merge register, in that order.
//  Busy is high only during reset; a synchronous reset empties the pipeline.
//  The receiver cannot stall, so done is a single-cycle strobe.
// ----------------------------------------------------------------------------
`include "rgba_pixel_blender_macros.svh"

module rgba_pixel_blender (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] mode,
  input  logic [7:0] base_red,
  input  logic [7:0] base_green,
  input  logic [7:0] base_blue,
  input  logic [7:0] base_alpha,
  input  logic [7:0] top_red,
  input  logic [7:0] top_green,
  input  logic [7:0] top_blue,
  input  logic [7:0] top_alpha,
  input  logic [7:0] opacity,
  output logic       done,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha
);
  import rpb_pkg::*;

  logic                accept;
  logic                s1_valid, s2_valid, s3_valid, s4_valid;
  mode_t               s1_mode;
  ctrl_t               s2_ctrl, s3_ctrl, s4_ctrl;
  pix_t                s1_base, s2_base, s3_base, s4_base;
  pix_t                s1_top, s2_top, s3_top, s4_top;
  logic [WEIGHT_W-1:0] s1_w;
  logic [WEIGHT_W-1:0] s1_wn;
  logic [CHAN_W-1:0]   lane_chan   [NUM_LANES];
  logic [WEIGHT_W-1:0] lane_weight [NUM_LANES];
  logic [CHAN_W-1:0]   lane_out    [NUM_LANES];
  pix_t                top_scl, base_scl, result;

  assign busy   = rst;
  assign accept = start && !busy;

  // Valid pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  // Capture the transaction and form the opacity weight.
  always_ff @(posedge clk) begin
    s1_mode <= mode_t'(mode);
    s1_base <= '{r: base_red, g: base_green, b: base_blue, a: base_alpha};
    s1_top  <= '{r: top_red, g: top_green, b: top_blue, a: top_alpha};
    s1_w    <= WEIGHT_W'(top_alpha) * WEIGHT_W'(opacity);
  end

  assign s1_wn = FULL_WEIGHT - s1_w;

  // Raw pixels and control follow the lanes.
  always_ff @(posedge clk) begin
    s2_ctrl <= '{mode: s1_mode, over: (s1_w > OVERLAY_THRESHOLD)};
    s3_ctrl <= s2_ctrl;
    s4_ctrl <= s3_ctrl;
    s2_base <= s1_base;
    s3_base <= s2_base;
    s4_base <= s3_base;
    s2_top  <= s1_top;
    s3_top  <= s2_top;
    s4_top  <= s3_top;
  end

  // Lanes 0 to 2 scale the top RGB by w, lanes 3 to 5 the base RGB by 65025 - w.
  assign lane_chan[0] = s1_top.r;
  assign lane_chan[1] = s1_top.g;
  assign lane_chan[2] = s1_top.b;
  assign lane_chan[3] = s1_base.r;
  assign lane_chan[4] = s1_base.g;
  assign lane_chan[5] = s1_base.b;

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    assign lane_weight[i] = (i < NUM_LANES / 2) ? s1_w : s1_wn;
    rpb_scale_lane u_lane (
      .clk    (clk),
      .chan   (lane_chan[i]),
      .weight (lane_weight[i]),
      .scaled (lane_out[i])
    );
  end

  assign top_scl  = '{r: lane_out[0], g: lane_out[1], b: lane_out[2], a: s4_top.a};
  assign base_scl = '{r: lane_out[3], g: lane_out[4], b: lane_out[5], a: s4_base.a};

  // Merge the lanes into the result.
  rpb_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .valid    (s4_valid),
    .ctrl     (s4_ctrl),
    .base_pix (s4_base),
    .top_pix  (s4_top),
    .base_scl (base_scl),
    .top_scl  (top_scl),
    .done     (done),
    .result   (result)
  );

  assign out_red   = result.r;
  assign out_green = result.g;
  assign out_blue  = result.b;
  assign out_alpha = result.a;

  // Every result strobe traces back to an accepted transaction.
  `RPB_ASSERT_IMP(a_done_origin, done, $past(accept, 5), "result without a transaction")
  // Replace mode returns the top pixel unchanged.
  `RPB_ASSERT_IMP(a_replace, accept && (mode == MODE_REPLACE),
    ##5 (done && out_red == $past(top_red, 5) && out_green == $past(top_green, 5) &&
         out_blue == $past(top_blue, 5) && out_alpha == $past(top_alpha, 5)),
    "replace mode did not return the top pixel")
  // With zero weight the scaled xor leaves the base pixel unchanged.
  `RPB_ASSERT_IMP(a_zero_weight, accept && (mode == MODE_XOR) && (opacity == 8'd0),
    ##5 (done && out_red == $past(base_red, 5) && out_green == $past(base_green, 5) &&
         out_blue == $past(base_blue, 5)),
    "zero weight altered the base pixel")
  // No strobe follows a cycle in which the merge stage input held no valid transaction.
  `RPB_ASSERT_NXT(a_strobe_follows, !s4_valid, !done, "strobe without a merged transaction")

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// RGBA pixel blender testbench
// Drives blend commands through the start/busy port. Every result strobe is
// compared with the pixel expected for the same command. A short table of
// directed commands comes first, then random commands under changing idle
// rates.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import rpb_pkg::*;

  // One blend command as it is presented on the input ports.
  typedef struct packed {
    mode_t       mode;
    pix_t        base;
    pix_t        top;
    logic [7:0]  amod;
  } blend_cmd_t;

  // One row of the directed table; known marks a hand-typed expected pixel.
  typedef struct packed {
    blend_cmd_t  cmd;
    bit          known;
    pix_t        want;
  } blend_row_t;

  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned TAIL_CYCLES  = 12;

  logic       clk = 1'b0;
  logic       rst;
  logic       start;
  logic       busy;
  logic [2:0] mode;
  logic [7:0] base_red;
  logic [7:0] base_green;
  logic [7:0] base_blue;
  logic [7:0] base_alpha;
  logic [7:0] top_red;
  logic [7:0] top_green;
  logic [7:0] top_blue;
  logic [7:0] top_alpha;
  logic [7:0] opacity;
  logic       done;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;

  // Pixels of driven commands not yet taken, and of taken commands whose
  // result has not come back yet.
  pix_t        staged_pixels[$];
  pix_t        pending_pixels[$];
  blend_row_t  blend_table[$];

  int unsigned errors       = 0;
  int unsigned stall_cycles = 0;
  int unsigned idle_pct     = 0;
  pix_t        got_pixel;
  pix_t        want_pixel;

  rgba_pixel_blender DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .mode           (mode),
    .base_red       (base_red),
    .base_green     (base_green),
    .base_blue      (base_blue),
    .base_alpha     (base_alpha),
    .top_red        (top_red),
    .top_green      (top_green),
    .top_blue       (top_blue),
    .top_alpha      (top_alpha),
    .opacity        (opacity),
    .done           (done),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_alpha      (out_alpha)
  );

  // Free-running 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Scale one channel by a weight out of full opacity, rounding down.
  function automatic int unsigned scale_chan(int unsigned c, int unsigned w);
    return (c * w) / 65025;
  endfunction

  // Add two channels, saturating at full scale.
  function automatic logic [7:0] sat_add(int unsigned a, int unsigned b);
    int unsigned s;
    s = a + b;
    return (s > 255) ? 8'd255 : s[7:0];
  endfunction

  // Predict the blended pixel for one command.
  function automatic pix_t blend_pixel(blend_cmd_t cmd);
    int unsigned w;
    int unsigned br, bg, bb, tr, tg, tb;
    pix_t        res;
    w  = 32'(cmd.top.a) * 32'(cmd.amod);
    br = 32'(cmd.base.r);
    bg = 32'(cmd.base.g);
    bb = 32'(cmd.base.b);
    tr = 32'(cmd.top.r);
    tg = 32'(cmd.top.g);
    tb = 32'(cmd.top.b);
    // The weighted modes scale both pixels before combining them.
    if (cmd.mode == MODE_XOR || cmd.mode == MODE_ADDITIVE) begin
      tr = scale_chan(tr, w);
      tg = scale_chan(tg, w);
      tb = scale_chan(tb, w);
      br = scale_chan(br, 65025 - w);
      bg = scale_chan(bg, 65025 - w);
      bb = scale_chan(bb, 65025 - w);
    end
    case (cmd.mode)
      MODE_DIRECT_XOR, MODE_XOR: begin
        res = '{r: 8'(br ^ tr), g: 8'(bg ^ tg), b: 8'(bb ^ tb), a: cmd.base.a};
      end
      MODE_ADDITIVE: begin
        res = '{r: sat_add(br, tr), g: sat_add(bg, tg), b: sat_add(bb, tb),
                a: cmd.base.a};
      end
      MODE_OVERLAY: begin
        if (w > 16129) begin
          res = '{r: 8'(tr), g: 8'(tg), b: 8'(tb), a: cmd.base.a};
        end else begin
          res = cmd.base;
        end
      end
      MODE_INVERT_DROP: begin
        res = '{r: 8'(br), g: 8'(bg), b: 8'(bb), a: 8'd255 - cmd.top.a};
      end
      MODE_DROP: begin
        res = '{r: 8'(br), g: 8'(bg), b: 8'(bb), a: cmd.top.a};
      end
      MODE_REPLACE: begin
        res = cmd.top;
      end
      default: begin
        res = cmd.base ^ cmd.top;
      end
    endcase
    return res;
  endfunction

  // Build a directed row; pixels are written as 0xRRGGBBAA.
  function automatic blend_row_t make_row(mode_t m, logic [31:0] base, logic [31:0] top,
                                          logic [7:0] amod, bit known, logic [31:0] want);
    blend_row_t row;
    row.cmd.mode = m;
    row.cmd.base = base;
    row.cmd.top  = top;
    row.cmd.amod = amod;
    row.known    = known;
    row.want     = want;
    return row;
  endfunction

  // Channel value with extra weight on the two extremes.
  function automatic logic [7:0] rand_chan();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      return 8'd0;
    end else if (pick < 30) begin
      return 8'd255;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Random command; the weight lands often on zero, full and the overlay edge.
  function automatic blend_cmd_t rand_cmd();
    blend_cmd_t cmd;
    cmd.mode = mode_t'($urandom_range(0, 7));
    cmd.base = '{r: rand_chan(), g: rand_chan(), b: rand_chan(), a: rand_chan()};
    cmd.top  = '{r: rand_chan(), g: rand_chan(), b: rand_chan(), a: rand_chan()};
    cmd.amod = rand_chan();
    case ($urandom_range(0, 9))
      0: begin
        cmd.amod = 8'd0;
      end
      1: begin
        cmd.top.a = 8'd255;
        cmd.amod  = 8'd255;
      end
      2: begin
        cmd.top.a = 8'd127;
        cmd.amod  = 8'($urandom_range(126, 128));
      end
      3: begin
        cmd.top.a = 8'($urandom_range(126, 128));
        cmd.amod  = 8'd127;
      end
      default: begin
      end
    endcase
    return cmd;
  endfunction

  // Print one mismatch line and count it.
  task automatic note_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Present one command and hold it until the block takes it. Idle cycles come
  // first, each one drawn with the current idle percentage, starting at the
  // edge where the previous transaction was taken.
  task automatic drive_cmd(blend_cmd_t cmd, pix_t want);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    mode           <= cmd.mode;
    base_red       <= cmd.base.r;
    base_green     <= cmd.base.g;
    base_blue      <= cmd.base.b;
    base_alpha     <= cmd.base.a;
    top_red        <= cmd.top.r;
    top_green      <= cmd.top.g;
    top_blue       <= cmd.top.b;
    top_alpha      <= cmd.top.a;
    opacity        <= cmd.amod;
    start          <= 1'b1;
    staged_pixels.push_back(want);
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Take transactions on both ports, compare results and watch for a hang.
  always @(posedge clk) begin
    if (done === 1'b1) begin
      got_pixel = '{r: out_red, g: out_green, b: out_blue, a: out_alpha};
      if (pending_pixels.size() == 0) begin
        note_mismatch($sformatf("result %08h with no pending transaction", got_pixel));
      end else begin
        want_pixel = pending_pixels.pop_front();
        if (got_pixel.r !== want_pixel.r) begin
          note_mismatch($sformatf("red %0d, expected %0d", got_pixel.r, want_pixel.r));
        end
        if (got_pixel.g !== want_pixel.g) begin
          note_mismatch($sformatf("green %0d, expected %0d", got_pixel.g, want_pixel.g));
        end
        if (got_pixel.b !== want_pixel.b) begin
          note_mismatch($sformatf("blue %0d, expected %0d", got_pixel.b, want_pixel.b));
        end
        if (got_pixel.a !== want_pixel.a) begin
          note_mismatch($sformatf("alpha %0d, expected %0d", got_pixel.a, want_pixel.a));
        end
      end
    end
    if (start === 1'b1 && busy === 1'b0) begin
      pending_pixels.push_back(staged_pixels.pop_front());
    end
    // Count cycles in which neither port moves a transaction.
    if (done === 1'b1 || (start === 1'b1 && busy === 1'b0)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // Stimulus, drain and final verdict.
  initial begin
    blend_cmd_t cmd;
    blend_row_t row;
    pix_t       want;

    rst            = 1'b1;
    start          = 1'b0;
    mode           = MODE_DIRECT_XOR;
    base_red       = 8'd0;
    base_green     = 8'd0;
    base_blue      = 8'd0;
    base_alpha     = 8'd0;
    top_red        = 8'd0;
    top_green      = 8'd0;
    top_blue       = 8'd0;
    top_alpha      = 8'd0;
    opacity        = 8'd0;

    // Directed table: extremes, every mode, overlay edge and zero weight.
    blend_table.push_back(make_row(MODE_DIRECT_XOR,  32'h00000000, 32'h00000000, 8'hff,
                                   1'b1, 32'h00000000));
    blend_table.push_back(make_row(MODE_DIRECT_XOR,  32'hffffffff, 32'hffffffff, 8'hff,
                                   1'b1, 32'h000000ff));
    blend_table.push_back(make_row(MODE_DIRECT_XOR,  32'haa55aa55, 32'h55aa55aa, 8'h80,
                                   1'b1, 32'hffffff55));
    blend_table.push_back(make_row(MODE_XOR_ALL,     32'hffffffff, 32'hffffffff, 8'hff,
                                   1'b1, 32'h00000000));
    blend_table.push_back(make_row(MODE_XOR_ALL,     32'h00000000, 32'hffffffff, 8'h00,
                                   1'b1, 32'hffffffff));
    blend_table.push_back(make_row(MODE_REPLACE,     32'h11223344, 32'h0c22384e, 8'h00,
                                   1'b1, 32'h0c22384e));
    blend_table.push_back(make_row(MODE_DROP,        32'h01020304, 32'hffffffc8, 8'h00,
                                   1'b1, 32'h010203c8));
    blend_table.push_back(make_row(MODE_INVERT_DROP, 32'h10203040, 32'haabbcc00, 8'hff,
                                   1'b1, 32'h102030ff));
    blend_table.push_back(make_row(MODE_INVERT_DROP, 32'h10203040, 32'haabbccff, 8'h00,
                                   1'b1, 32'h10203000));
    // Overlay: a weight equal to the threshold keeps the base pixel.
    blend_table.push_back(make_row(MODE_OVERLAY,     32'h10203040, 32'ha0b0c07f, 8'h7f,
                                   1'b1, 32'h10203040));
    blend_table.push_back(make_row(MODE_OVERLAY,     32'h10203040, 32'ha0b0c07f, 8'h80,
                                   1'b1, 32'ha0b0c040));
    blend_table.push_back(make_row(MODE_OVERLAY,     32'h10203040, 32'ha0b0c0ff, 8'hff,
                                   1'b1, 32'ha0b0c040));
    blend_table.push_back(make_row(MODE_OVERLAY,     32'hffffffff, 32'h00000000, 8'hff,
                                   1'b1, 32'hffffffff));
    // Zero weight leaves the base channels and drops the top ones.
    blend_table.push_back(make_row(MODE_XOR,         32'h123456ff, 32'habcdef80, 8'h00,
                                   1'b1, 32'h123456ff));
    blend_table.push_back(make_row(MODE_XOR,         32'h123456ff, 32'habcdefff, 8'hff,
                                   1'b1, 32'habcdefff));
    blend_table.push_back(make_row(MODE_ADDITIVE,    32'h80808080, 32'hffffff00, 8'hff,
                                   1'b1, 32'h80808080));
    blend_table.push_back(make_row(MODE_ADDITIVE,    32'h80808080, 32'h40506aff, 8'hff,
                                   1'b1, 32'h40506a80));
    blend_table.push_back(make_row(MODE_ADDITIVE,    32'h00000000, 32'hffffffff, 8'hff,
                                   1'b1, 32'hffffff00));
    // Mid weights go to the predictor.
    blend_table.push_back(make_row(MODE_ADDITIVE,    32'hffffffff, 32'hffffff80, 8'hff,
                                   1'b0, 32'h0));
    blend_table.push_back(make_row(MODE_ADDITIVE,    32'hc8c8c8c8, 32'hfafafac8, 8'hb4,
                                   1'b0, 32'h0));
    blend_table.push_back(make_row(MODE_XOR,         32'h5a5a5a5a, 32'ha5a5a5a5, 8'h40,
                                   1'b0, 32'h0));
    blend_table.push_back(make_row(MODE_XOR,         32'hffffffff, 32'hffffff01, 8'h01,
                                   1'b0, 32'h0));
    blend_table.push_back(make_row(MODE_OVERLAY,     32'h12345678, 32'h9abcdef0, 8'h11,
                                   1'b0, 32'h0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    idle_pct = 28;
    foreach (blend_table[i]) begin
      row  = blend_table[i];
      want = row.known ? row.want : blend_pixel(row.cmd);
      drive_cmd(row.cmd, want);
    end

    // Random commands in three idle regimes.
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        idle_pct = 52;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        idle_pct = 0;
      end
      cmd = rand_cmd();
      drive_cmd(cmd, blend_pixel(cmd));
    end
    start <= 1'b0;

    // Drain the pipeline, then watch a few more cycles for stray results.
    while (pending_pixels.size() != 0 || staged_pixels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (pending_pixels.size() != 0) begin
      note_mismatch($sformatf("%0d results never arrived", pending_pixels.size()));
    end
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
